[src/whlf_pkg.sv]
// Shared types, constants and arithmetic helpers for the water hammer update block.
package whlf_pkg;

  // Fixed-point format of pressures, flows and the gravity term
  localparam int FRAC_BITS = 16;
  localparam int VAL_W     = 32;
  // Coefficients are unsigned Q8.24
  localparam int COEF_W    = 32;
  localparam int COEF_FRAC = 24;

  // Shared multiplier: 33 x 33 signed operands
  localparam int MUL_W  = 33;
  localparam int PROD_W = 2 * MUL_W;
  // Friction square term q*|q| >> FRAC_BITS, split at the coefficient fraction point
  localparam int SQ_W   = 2 * VAL_W - 1 - FRAC_BITS;
  localparam int SH_W   = SQ_W - COEF_FRAC;
  localparam int LOW_W  = 32;
  // Clamped product terms (magnitude up to 2^40) and the wide sums around them
  localparam int TERM_LIM_BITS = 40;
  localparam int TERM_W = TERM_LIM_BITS + 2;
  localparam int WIDE_W = PROD_W + 1;
  localparam int SUM_W  = TERM_W + 2;

  localparam longint TERM_LIMIT = 64'sd1 <<< TERM_LIM_BITS;
  localparam longint S32_MAX    = 64'sd2147483647;
  localparam longint S32_MIN    = -64'sd2147483648;

  // Configuration register indexes
  localparam int REG_IDX_W = 2;
  localparam logic [REG_IDX_W-1:0] REG_PRESSURE_COUPLING = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_FLOW_COUPLING     = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_FRICTION_GAIN     = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_GRAVITY_STEP      = 2'd3;

  // Multiplier operand selection
  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_SQ,
    MUL_P,
    MUL_F,
    MUL_FL,
    MUL_FH
  } mul_op_t;

  // Which register takes the registered product
  typedef enum logic [2:0] {
    CAP_NONE,
    CAP_SQ,
    CAP_P,
    CAP_F,
    CAP_LOW,
    CAP_FRIC
  } cap_t;

  // Source of an output beat
  typedef enum logic [1:0] {
    OSEL_PRIOR,
    OSEL_STENCIL,
    OSEL_CUR
  } out_sel_t;

  typedef struct packed {
    logic     take;
    mul_op_t  mul_op;
    cap_t     cap;
    logic     sum;
    logic     shift;
    logic     out_load;
    out_sel_t out_sel;
    logic     out_last;
  } dp_cmd_t;

  typedef struct packed {
    logic cur_last;
    logic out_free;
  } dp_stat_t;

  // Limit a product term to +/- 2^40
  function automatic logic signed [TERM_W-1:0] clamp_term(input logic signed [WIDE_W-1:0] x);
    logic signed [WIDE_W-1:0] hi;
    logic signed [WIDE_W-1:0] lo;
    hi = WIDE_W'(TERM_LIMIT);
    lo = -WIDE_W'(TERM_LIMIT);
    if (x > hi) begin
      return TERM_W'(hi);
    end else if (x < lo) begin
      return TERM_W'(lo);
    end
    return TERM_W'(x);
  endfunction

  // Saturate a wide sum to the signed 32-bit range
  function automatic logic signed [VAL_W-1:0] sat32(input logic signed [SUM_W-1:0] x);
    if (x > SUM_W'(S32_MAX)) begin
      return VAL_W'(S32_MAX);
    end else if (x < SUM_W'(S32_MIN)) begin
      return VAL_W'(S32_MIN);
    end
    return VAL_W'(x);
  endfunction

endpackage

[src/whlf_ctrl.sv]
// Sequencer for the water hammer update: input handshake, multiply schedule and output loads.
module whlf_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  whlf_pkg::dp_stat_t stat,
  output whlf_pkg::dp_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_MUL_SQ,
    S_MUL_P,
    S_MUL_F,
    S_MUL_FL,
    S_MUL_FH,
    S_FRIC,
    S_SUM,
    S_EMIT_HELD,
    S_EMIT_NEW
  } state_t;

  state_t     state_r, state_nxt;
  logic [1:0] cnt_r, cnt_nxt;   // cells held in the delay line

  // Hold state and the held-cell count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= 2'd0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  assign in_tready = (state_r == S_IDLE);

  // Next state and datapath commands
  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    cmd          = '0;
    cmd.mul_op   = whlf_pkg::MUL_NONE;
    cmd.cap      = whlf_pkg::CAP_NONE;
    cmd.out_sel  = whlf_pkg::OSEL_PRIOR;
    unique case (state_r)
      S_IDLE: begin
        cmd.take = in_tvalid;
        if (in_tvalid) begin
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (cnt_r == 2'd0) begin
          if (stat.cur_last) begin
            state_nxt = S_EMIT_NEW;
          end else begin
            cmd.shift = 1'b1;
            cnt_nxt   = 2'd1;
            state_nxt = S_IDLE;
          end
        end else if (cnt_r == 2'd1) begin
          state_nxt = S_EMIT_HELD;
        end else begin
          state_nxt = S_MUL_SQ;
        end
      end
      S_MUL_SQ: begin
        cmd.mul_op = whlf_pkg::MUL_SQ;
        state_nxt  = S_MUL_P;
      end
      S_MUL_P: begin
        cmd.mul_op = whlf_pkg::MUL_P;
        cmd.cap    = whlf_pkg::CAP_SQ;
        state_nxt  = S_MUL_F;
      end
      S_MUL_F: begin
        cmd.mul_op = whlf_pkg::MUL_F;
        cmd.cap    = whlf_pkg::CAP_P;
        state_nxt  = S_MUL_FL;
      end
      S_MUL_FL: begin
        cmd.mul_op = whlf_pkg::MUL_FL;
        cmd.cap    = whlf_pkg::CAP_F;
        state_nxt  = S_MUL_FH;
      end
      S_MUL_FH: begin
        cmd.mul_op = whlf_pkg::MUL_FH;
        cmd.cap    = whlf_pkg::CAP_LOW;
        state_nxt  = S_FRIC;
      end
      S_FRIC: begin
        cmd.cap   = whlf_pkg::CAP_FRIC;
        state_nxt = S_SUM;
      end
      S_SUM: begin
        cmd.sum   = 1'b1;
        state_nxt = S_EMIT_HELD;
      end
      S_EMIT_HELD: begin
        // Emit the held cell, then either finish the segment or advance the line
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_sel  = (cnt_r == 2'd1) ? whlf_pkg::OSEL_PRIOR : whlf_pkg::OSEL_STENCIL;
          if (stat.cur_last) begin
            state_nxt = S_EMIT_NEW;
          end else begin
            cmd.shift = 1'b1;
            cnt_nxt   = 2'd2;
            state_nxt = S_IDLE;
          end
        end
      end
      S_EMIT_NEW: begin
        // Pass the last cell through unchanged and restart the segment
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_sel  = whlf_pkg::OSEL_CUR;
          cmd.out_last = 1'b1;
          cnt_nxt      = 2'd0;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

[src/whlf_dp.sv]
// Datapath: coefficient registers, two-cell delay line, shared multiplier and output register.
module whlf_dp (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    cfg_we,
  input  logic [whlf_pkg::REG_IDX_W-1:0]          cfg_index,
  input  logic [whlf_pkg::COEF_W-1:0]             cfg_wdata,
  input  logic signed [whlf_pkg::VAL_W-1:0]       in_pressure,
  input  logic signed [whlf_pkg::VAL_W-1:0]       in_flow,
  input  logic                                    in_last,
  input  whlf_pkg::dp_cmd_t                       cmd,
  output whlf_pkg::dp_stat_t                      stat,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic signed [whlf_pkg::VAL_W-1:0]       out_pressure,
  output logic signed [whlf_pkg::VAL_W-1:0]       out_flow,
  output logic                                    out_last
);

  localparam int VW = whlf_pkg::VAL_W;
  localparam int MW = whlf_pkg::MUL_W;
  localparam int PW = whlf_pkg::PROD_W;
  localparam int WW = whlf_pkg::WIDE_W;
  localparam int SW = whlf_pkg::SUM_W;
  localparam int CF = whlf_pkg::COEF_FRAC;

  // Coefficients
  logic [whlf_pkg::COEF_W-1:0] pcoup_r, fcoup_r, fgain_r;
  logic signed [VW-1:0]        grav_r;

  // Delay line and the cell just taken
  logic signed [VW-1:0] older_p_r, older_q_r, prior_p_r, prior_q_r, cur_p_r, cur_q_r;
  logic                 cur_last_r;

  // Multiplier and product terms
  logic signed [MW-1:0]                    mul_a, mul_b;
  logic signed [PW-1:0]                    prod_r;
  logic signed [whlf_pkg::SQ_W-1:0]        sq_r;
  logic signed [whlf_pkg::TERM_W-1:0]      pterm_r, fterm_r, fric_r;
  logic [whlf_pkg::LOW_W-1:0]              low_r;
  logic signed [VW-1:0]                    np_r, nq_r;

  // Operand helpers
  logic signed [MW-1:0]                    cq_ext, mag, dq, dp;
  logic [whlf_pkg::SH_W-1:0]               sh;
  logic signed [SW-1:0]                    mean_p, mean_q, np_sum, nq_sum;

  // Output register
  logic                 out_valid_r;
  logic signed [VW-1:0] out_p_r, out_q_r;
  logic                 out_last_r;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pcoup_r <= '0;
      fcoup_r <= '0;
      fgain_r <= '0;
      grav_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        whlf_pkg::REG_PRESSURE_COUPLING: pcoup_r <= cfg_wdata;
        whlf_pkg::REG_FLOW_COUPLING:     fcoup_r <= cfg_wdata;
        whlf_pkg::REG_FRICTION_GAIN:     fgain_r <= cfg_wdata;
        whlf_pkg::REG_GRAVITY_STEP:      grav_r  <= $signed(cfg_wdata);
        default: ;
      endcase
    end
  end

  // Take a cell and advance the delay line
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      cur_p_r    <= in_pressure;
      cur_q_r    <= in_flow;
      cur_last_r <= in_last;
    end
    if (cmd.shift) begin
      older_p_r <= prior_p_r;
      older_q_r <= prior_q_r;
      prior_p_r <= cur_p_r;
      prior_q_r <= cur_q_r;
    end
  end

  // Operand preparation
  assign cq_ext = MW'(prior_q_r);
  assign mag    = prior_q_r[VW-1] ? -cq_ext : cq_ext;
  assign dq     = MW'(cur_q_r) - MW'(older_q_r);
  assign dp     = MW'(cur_p_r) - MW'(older_p_r);
  assign sh     = sq_r[whlf_pkg::SQ_W-1:CF];

  // Select multiplier operands
  always_comb begin
    case (cmd.mul_op)
      whlf_pkg::MUL_SQ: begin
        mul_a = cq_ext;
        mul_b = mag;
      end
      whlf_pkg::MUL_P: begin
        mul_a = $signed({1'b0, pcoup_r});
        mul_b = dq;
      end
      whlf_pkg::MUL_F: begin
        mul_a = $signed({1'b0, fcoup_r});
        mul_b = dp;
      end
      whlf_pkg::MUL_FL: begin
        mul_a = $signed({1'b0, fgain_r});
        mul_b = $signed(MW'(sq_r[CF-1:0]));
      end
      whlf_pkg::MUL_FH: begin
        mul_a = $signed({1'b0, fgain_r});
        mul_b = MW'($signed(sh));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Register the product, then capture it into its term
  always_ff @(posedge clk) begin
    prod_r <= PW'(mul_a) * PW'(mul_b);
    case (cmd.cap)
      whlf_pkg::CAP_SQ:   sq_r    <= whlf_pkg::SQ_W'(prod_r >>> whlf_pkg::FRAC_BITS);
      whlf_pkg::CAP_P:    pterm_r <= whlf_pkg::clamp_term(WW'(prod_r >>> CF));
      whlf_pkg::CAP_F:    fterm_r <= whlf_pkg::clamp_term(WW'(prod_r >>> CF));
      whlf_pkg::CAP_LOW:  low_r   <= whlf_pkg::LOW_W'(prod_r >>> CF);
      whlf_pkg::CAP_FRIC: fric_r  <= whlf_pkg::clamp_term(WW'(prod_r)
                                       + WW'($signed({1'b0, low_r})));
      default: ;
    endcase
  end

  // Stencil sums: floor means less the coupling and friction terms, plus the gravity term
  assign mean_p = (SW'(older_p_r) + SW'(cur_p_r)) >>> 1;
  assign mean_q = (SW'(older_q_r) + SW'(cur_q_r)) >>> 1;
  assign np_sum = mean_p - SW'(pterm_r);
  assign nq_sum = mean_q - SW'(fterm_r) - SW'(fric_r) + SW'(grav_r);

  always_ff @(posedge clk) begin
    if (cmd.sum) begin
      np_r <= whlf_pkg::sat32(np_sum);
      nq_r <= whlf_pkg::sat32(nq_sum);
    end
  end

  // Output register: load a beat, drop it once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_last_r <= cmd.out_last;
      case (cmd.out_sel)
        whlf_pkg::OSEL_STENCIL: begin
          out_p_r <= np_r;
          out_q_r <= nq_r;
        end
        whlf_pkg::OSEL_CUR: begin
          out_p_r <= cur_p_r;
          out_q_r <= cur_q_r;
        end
        default: begin
          out_p_r <= prior_p_r;
          out_q_r <= prior_q_r;
        end
      endcase
    end
  end

  assign stat.cur_last = cur_last_r;
  assign stat.out_free = !out_valid_r || out_ready;

  assign out_valid    = out_valid_r;
  assign out_pressure = out_p_r;
  assign out_flow     = out_q_r;
  assign out_last     = out_last_r;

endmodule

[src/water_hammer_lax_friedrichs_step.sv]
// Top level of the streaming Lax-Friedrichs water hammer cell update.
// A beat goes to a dispatch state; a cell it releases as passed through then loads the output,
// while a stencil result first takes five passes through the shared 33x33 multiplier, then the
// friction and sum stages; a last cell loads after the prior one. A new cell is taken only when
// the block is back in idle, so an output stall also holds the input.
// Reset: synchronous, active low; clears coefficients to zero and restarts at segment start.
module water_hammer_lax_friedrichs_step (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // configuration write port
  input  logic                                 cfg_we,
  input  logic [whlf_pkg::REG_IDX_W-1:0]       cfg_index,
  input  logic [whlf_pkg::COEF_W-1:0]          cfg_wdata,
  // input cells
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [2*whlf_pkg::VAL_W-1:0]         in_tdata,   // [31:0] in_pressure, [63:32] in_flow
  input  logic                                 in_tlast,
  // updated cells
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [2*whlf_pkg::VAL_W-1:0]         out_tdata,  // [31:0] out_pressure, [63:32] out_flow
  output logic                                 out_tlast
);

  localparam int VW = whlf_pkg::VAL_W;

  whlf_pkg::dp_cmd_t  cmd;
  whlf_pkg::dp_stat_t stat;
  logic signed [VW-1:0] out_p, out_q;

  whlf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  whlf_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .in_pressure  ($signed(in_tdata[VW-1:0])),
    .in_flow      ($signed(in_tdata[2*VW-1:VW])),
    .in_last      (in_tlast),
    .cmd          (cmd),
    .stat         (stat),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .out_pressure (out_p),
    .out_flow     (out_q),
    .out_last     (out_tlast)
  );

  // Pack the result beat
  assign out_tdata = {out_q, out_p};

endmodule

[tb/water_hammer_lax_friedrichs_step_tb.sv]
// Self-checking stream testbench for the Lax-Friedrichs water hammer cell update.
module water_hammer_lax_friedrichs_step_tb;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int SETTLE_CYCLES  = 20;
  localparam int PHASE_CELLS    = 290;
  localparam logic signed [127:0] PRODUCT_CAP = 128'sd1 <<< 40;

  typedef struct {
    logic signed [31:0] pressure;
    logic signed [31:0] flow;
    logic               last;
  } cell_t;

  typedef enum {MODE_ZERO, MODE_SMALL, MODE_MAX, MODE_WIDE} coef_mode_t;

  logic                           clk;
  logic                           rst_n;
  logic                           cfg_we;
  logic [whlf_pkg::REG_IDX_W-1:0] cfg_index;
  logic [whlf_pkg::COEF_W-1:0]    cfg_wdata;
  logic                           in_tvalid;
  logic                           in_tready;
  logic [63:0]                    in_tdata;   // [31:0] in_pressure, [63:32] in_flow
  logic                           in_tlast;
  logic                           out_tvalid;
  logic                           out_tready;
  logic [63:0]                    out_tdata;  // [31:0] out_pressure, [63:32] out_flow
  logic                           out_tlast;

  // Cells waiting to be sent and cells the block should return
  cell_t cell_q[$];
  cell_t expected_cells[$];

  // Shadow of the block's coefficients and two-cell delay line
  logic [31:0]        press_coef;
  logic [31:0]        flow_coef;
  logic [31:0]        fric_coef;
  logic signed [31:0] gravity;
  cell_t              held_left;
  cell_t              held_mid;
  int                 cells_held;

  int  cells_queued;
  int  cells_taken;
  int  fail_count;
  int  quiet_cycles;
  int  in_gap;
  int  stall_left;
  bit  idle_on;
  bit  in_taken;

  water_hammer_lax_friedrichs_step dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // floor(c * x / 2^24) on the exact product, magnitude capped at 2^40
  function automatic logic signed [127:0] coef_mul(input logic [31:0] c,
                                                   input logic signed [127:0] x);
    logic signed [127:0] prod;
    prod = $signed({96'd0, c}) * x;
    prod = prod >>> whlf_pkg::COEF_FRAC;
    if (prod > PRODUCT_CAP) begin
      prod = PRODUCT_CAP;
    end else if (prod < -PRODUCT_CAP) begin
      prod = -PRODUCT_CAP;
    end
    return prod;
  endfunction

  function automatic logic signed [31:0] clip_s32(input logic signed [127:0] x);
    if (x > 128'sd2147483647) begin
      return 32'h7FFF_FFFF;
    end else if (x < -128'sd2147483648) begin
      return 32'h8000_0000;
    end
    return x[31:0];
  endfunction

  // Advance the delay line by one taken cell and queue the cells it releases
  function automatic void update_segment(input cell_t arriving);
    logic signed [127:0] lp, lq, rp, rq, cq, sq, np, nq;
    cell_t done;
    if (cells_held == 0) begin
      if (arriving.last) begin
        expected_cells.push_back(arriving);
      end else begin
        held_mid   = arriving;
        cells_held = 1;
      end
      return;
    end
    if (cells_held == 1) begin
      // first cell of the segment passes through
      done = '{held_mid.pressure, held_mid.flow, 1'b0};
    end else begin
      lp = held_left.pressure;
      lq = held_left.flow;
      rp = arriving.pressure;
      rq = arriving.flow;
      cq = held_mid.flow;
      sq = (cq * ((cq < 0) ? -cq : cq)) >>> whlf_pkg::FRAC_BITS;
      np = ((lp + rp) >>> 1) - coef_mul(press_coef, rq - lq);
      nq = ((lq + rq) >>> 1) - coef_mul(flow_coef, rp - lp) - coef_mul(fric_coef, sq)
           + gravity;
      done = '{clip_s32(np), clip_s32(nq), 1'b0};
    end
    expected_cells.push_back(done);
    if (arriving.last) begin
      expected_cells.push_back(arriving);
      cells_held = 0;
    end else begin
      held_left  = held_mid;
      held_mid   = arriving;
      cells_held = 2;
    end
  endfunction

  // Mostly no gap, some short ones, a few long ones
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end else if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 60);
  endfunction

  // Mix of extremes, full-range words and moderate Q16.16 values
  function automatic logic [31:0] rand_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) begin
      case ($urandom_range(0, 3))
        0: return 32'h7FFF_FFFF;
        1: return 32'h8000_0000;
        2: return 32'h0000_0000;
        default: return 32'hFFFF_FFFF;
      endcase
    end else if (r < 30) begin
      return $urandom();
    end
    return $urandom_range(0, 32'h003F_FFFF) - 32'h0020_0000;
  endfunction

  function automatic logic [31:0] rand_coef(input coef_mode_t mode);
    case (mode)
      MODE_ZERO:  return 32'd0;
      MODE_SMALL: return $urandom_range(0, 32'h0040_0000);
      MODE_MAX:   return 32'hFFFF_FFFF;
      default:    return $urandom();
    endcase
  endfunction

  function automatic logic [31:0] rand_gravity(input coef_mode_t mode);
    case (mode)
      MODE_ZERO:  return 32'd0;
      MODE_SMALL: return $urandom_range(0, 32'h0001_FFFF) - 32'h0001_0000;
      MODE_MAX:   return 32'h7FFF_FFFF;
      default:    return $urandom();
    endcase
  endfunction

  function automatic int rand_seg_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) begin
      return 1;
    end else if (r < 20) begin
      return 2;
    end else if (r < 85) begin
      return $urandom_range(3, 12);
    end
    return $urandom_range(13, 40);
  endfunction

  task automatic push_cell(input logic [31:0] p, input logic [31:0] q, input logic last);
    cell_q.push_back('{p, q, last});
    cells_queued++;
  endtask

  // Wait until every queued cell is taken and every result has come back
  task automatic drain_all();
    do begin
      @(negedge clk);
    end while (cells_taken != cells_queued || expected_cells.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [whlf_pkg::REG_IDX_W-1:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
  endtask

  task automatic set_coefs(input logic [31:0] pc, input logic [31:0] fc,
                           input logic [31:0] fg, input logic [31:0] gs);
    drain_all();
    write_reg(whlf_pkg::REG_PRESSURE_COUPLING, pc);
    write_reg(whlf_pkg::REG_FLOW_COUPLING, fc);
    write_reg(whlf_pkg::REG_FRICTION_GAIN, fg);
    write_reg(whlf_pkg::REG_GRAVITY_STEP, gs);
    @(negedge clk);
    cfg_we     <= 1'b0;
    press_coef = pc;
    flow_coef  = fc;
    fric_coef  = fg;
    gravity    = gs;
  endtask

  // Stimulus: directed corners, then randomized phases under several settings
  initial begin
    coef_mode_t mode_plan[6];
    coef_mode_t mode;
    int         sent;
    int         len;
    mode_plan = '{MODE_SMALL, MODE_WIDE, MODE_ZERO, MODE_SMALL, MODE_MAX, MODE_SMALL};
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_index    = '0;
    cfg_wdata    = '0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    in_tlast     = 1'b0;
    out_tready   = 1'b0;
    press_coef   = '0;
    flow_coef    = '0;
    fric_coef    = '0;
    gravity      = '0;
    cells_held   = 0;
    cells_queued = 0;
    cells_taken  = 0;
    fail_count   = 0;
    quiet_cycles = 0;
    in_gap       = 0;
    stall_left   = 0;
    idle_on      = 1'b1;
    in_taken     = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset coefficients: single-cell segment, two-cell segment, extreme means
    push_cell(32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
    push_cell(32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
    push_cell(32'h0000_0000, 32'hFFFF_FFFF, 1'b1);
    push_cell(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
    push_cell(32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
    push_cell(32'h8000_0000, 32'h8000_0000, 1'b0);
    push_cell(32'hFFFF_FFFF, 32'h0000_0001, 1'b0);
    push_cell(32'h0000_0003, 32'hFFFF_FFFD, 1'b1);

    // Moderate coefficients on a short segment
    set_coefs(32'h0080_0000, 32'h0100_0000, 32'h0001_0000, 32'h0000_8000);
    push_cell(32'h0001_0000, 32'h0002_0000, 1'b0);
    push_cell(32'hFFFF_0000, 32'h0003_0000, 1'b0);
    push_cell(32'h0005_0000, 32'hFFFD_0000, 1'b0);
    push_cell(32'h0000_1000, 32'h0000_0001, 1'b1);

    // Largest coefficients with both gravity extremes: clamped products, saturation
    set_coefs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
    push_cell(32'h0000_0000, 32'h0000_0000, 1'b0);
    push_cell(32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
    push_cell(32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
    set_coefs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000);
    push_cell(32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
    push_cell(32'h0000_0001, 32'h8000_0000, 1'b0);
    push_cell(32'h8000_0000, 32'h7FFF_FFFF, 1'b1);

    // Random segments, one coefficient setting per phase
    foreach (mode_plan[ph]) begin
      mode = mode_plan[ph];
      set_coefs(rand_coef(mode), rand_coef(mode), rand_coef(mode), rand_gravity(mode));
      idle_on = (mode != MODE_ZERO);
      sent = 0;
      while (sent < PHASE_CELLS) begin
        len = rand_seg_len();
        for (int k = 0; k < len; k++) begin
          push_cell(rand_value(), rand_value(), k == len - 1);
        end
        sent += len;
        // hold off the sender until the block has emptied
        if (sent > PHASE_CELLS / 2 && sent - len <= PHASE_CELLS / 2) begin
          drain_all();
        end
      end
    end

    drain_all();
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Drive input beats from the pending queue at the falling edge
  always @(negedge clk) begin
    cell_t nxt;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (in_tvalid && !in_taken) begin
      // hold the beat until it is taken
    end else if (in_gap > 0) begin
      in_gap    <= in_gap - 1;
      in_tvalid <= 1'b0;
    end else if (cell_q.size() != 0) begin
      nxt = cell_q.pop_front();
      in_tdata  <= {nxt.flow, nxt.pressure};
      in_tlast  <= nxt.last;
      in_tvalid <= 1'b1;
      in_gap    <= idle_on ? idle_len() : 0;
    end else begin
      in_tvalid <= 1'b0;
    end
  end

  // Stall the result side at random while input gaps are on
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (!idle_on) begin
      out_tready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if ($urandom_range(0, 99) < 75) begin
      out_tready <= 1'b1;
    end else begin
      stall_left <= idle_len();
      out_tready <= 1'b0;
    end
  end

  // Sample both channels at the rising edge: predict, compare, watch for a hang
  always @(posedge clk) begin
    cell_t taken;
    cell_t want;
    if (rst_n) begin
      in_taken <= in_tvalid && in_tready;
      if (in_tvalid && in_tready) begin
        taken = '{in_tdata[31:0], in_tdata[63:32], in_tlast};
        update_segment(taken);
        cells_taken++;
      end
      if (out_tvalid && out_tready) begin
        if (expected_cells.size() == 0) begin
          $error("out beat with no result expected: out_pressure %0d, out_flow %0d",
                 $signed(out_tdata[31:0]), $signed(out_tdata[63:32]));
          fail_count++;
        end else begin
          want = expected_cells.pop_front();
          if (out_tdata[31:0] !== want.pressure) begin
            $error("out_pressure: expected %0d, got %0d", want.pressure,
                   $signed(out_tdata[31:0]));
            fail_count++;
          end
          if (out_tdata[63:32] !== want.flow) begin
            $error("out_flow: expected %0d, got %0d", want.flow,
                   $signed(out_tdata[63:32]));
            fail_count++;
          end
          if (out_tlast !== want.last) begin
            $error("out_last: expected %0d, got %0d", want.last, out_tlast);
            fail_count++;
          end
        end
      end
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $error("no beat for %0d cycles, %0d results still expected", quiet_cycles,
               expected_cells.size());
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

endmodule
